@@ rtl/bmts_pkg.sv @@
`default_nettype none

package bmts_pkg;

   localparam int ROW_SLOTS            = 32;
   localparam int IDX_W                = 5;
   localparam int CNT_W                = 6;
   localparam int DEFAULT_MAX_VERTICES = 32;
   localparam logic [CNT_W-1:0] RESET_VERTEX_COUNT = 6'd32;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_CHECK = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   typedef struct packed {
      logic                 en;
      logic [IDX_W-1:0]     addr;
      logic [ROW_SLOTS-1:0] data;
   } row_wr_type;

endpackage

`default_nettype wire

@@ rtl/bmts_row_store.sv @@
`default_nettype none

module bmts_row_store (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              clear_all,
   input  wire bmts_pkg::row_wr_type              wr,
   input  wire logic [bmts_pkg::IDX_W-1:0]        rd_addr,
   output logic      [bmts_pkg::ROW_SLOTS-1:0]    rd_data
);

   logic [bmts_pkg::ROW_SLOTS-1:0] rows_ff [bmts_pkg::ROW_SLOTS];
   logic [bmts_pkg::ROW_SLOTS-1:0] valid_ff;
   logic [bmts_pkg::ROW_SLOTS-1:0] valid_in;

   // A row that was never written since the last clear reads as zero.
   always_comb begin
      valid_in = valid_ff;
      if (clear_all) begin
         valid_in = '0;
      end else if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         rows_ff[wr.addr] <= wr.data;
      end
   end

   assign rd_data = valid_ff[rd_addr] ? rows_ff[rd_addr] : '0;

endmodule

`default_nettype wire

@@ rtl/bit_matrix_topological_sort.sv @@
`default_nettype none

// Loads the adjacency rows of a directed graph, one item per cycle while busy
// is low, and runs a layered Kahn sort when an item with req_start_sort set
// arrives. A row load without req_start_sort gives no result. During a sort
// busy stays high; each round reads the n vertex rows one per cycle through a
// single read port, ORing the rows of vertices not yet emitted into one OR
// accumulator, then does the free-vertex check, then walks the n vertex
// positions one per cycle, emitting every free vertex in ascending order.
// Here n is the effective vertex count. Results appear on the rsp_ ports for
// exactly one cycle each, marked by rsp_valid; the receiver cannot stall them
// and must take every item as it comes. The row store is cleared when the
// sort ends.
module bit_matrix_topological_sort #(
   parameter int MAX_VERTICES = bmts_pkg::DEFAULT_MAX_VERTICES
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [bmts_pkg::IDX_W-1:0]        req_row_index,
   input  wire logic [bmts_pkg::ROW_SLOTS-1:0]    req_row_bits,
   input  wire logic                              req_start_sort,
   output logic                                   rsp_valid,
   output logic      [bmts_pkg::CNT_W-1:0]        rsp_vertex_number,
   output logic                                   rsp_cycle_found,
   output logic                                   rsp_last,
   input  wire logic                              csr_we,
   input  wire logic [bmts_pkg::CNT_W-1:0]        csr_wdata
);

   localparam int LIMIT = (MAX_VERTICES < bmts_pkg::ROW_SLOTS) ?
                          MAX_VERTICES : bmts_pkg::ROW_SLOTS;

   bmts_pkg::state_type state_ff, state_in;

   logic [bmts_pkg::CNT_W-1:0]     vcount_ff, vcount_in;
   logic [bmts_pkg::CNT_W-1:0]     n_ff, n_in;
   logic [bmts_pkg::IDX_W-1:0]     idx_ff, idx_in;
   logic [bmts_pkg::CNT_W-1:0]     emitted_ff, emitted_in;
   logic [bmts_pkg::ROW_SLOTS-1:0] incoming_ff, incoming_in;
   logic [bmts_pkg::ROW_SLOTS-1:0] removed_ff, removed_in;
   logic [bmts_pkg::ROW_SLOTS-1:0] freed_ff, freed_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [bmts_pkg::CNT_W-1:0]     rsp_num_ff, rsp_num_in;
   logic                           rsp_cyc_ff, rsp_cyc_in;
   logic                           rsp_last_ff, rsp_last_in;

   bmts_pkg::row_wr_type           row_wr;
   logic                           clear_all;
   logic [bmts_pkg::ROW_SLOTS-1:0] rd_data;
   logic [bmts_pkg::ROW_SLOTS-1:0] all_mask;
   logic [bmts_pkg::ROW_SLOTS-1:0] freed_now;
   logic [bmts_pkg::CNT_W-1:0]     eff_count;
   logic                           accept;
   logic                           idx_at_end;

   bmts_row_store u_store (
      .clock     (clock),
      .reset     (reset),
      .clear_all (clear_all),
      .wr        (row_wr),
      .rd_addr   (idx_ff),
      .rd_data   (rd_data)
   );

   assign busy   = (state_ff != bmts_pkg::ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      eff_count = vcount_ff;
      if (vcount_ff == '0) begin
         eff_count = bmts_pkg::CNT_W'(1);
      end else if (vcount_ff > bmts_pkg::CNT_W'(LIMIT)) begin
         eff_count = bmts_pkg::CNT_W'(LIMIT);
      end
   end

   always_comb begin
      for (int j = 0; j < bmts_pkg::ROW_SLOTS; j++) begin
         all_mask[j] = (bmts_pkg::CNT_W'(j) < n_ff);
      end
   end

   assign freed_now  = ~incoming_ff & ~removed_ff & all_mask;
   assign idx_at_end = ({1'b0, idx_ff} == (n_ff - bmts_pkg::CNT_W'(1)));

   always_comb begin
      row_wr.en   = accept;
      row_wr.addr = req_row_index;
      row_wr.data = req_row_bits;
   end

   always_comb begin
      state_in     = state_ff;
      vcount_in    = vcount_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      emitted_in   = emitted_ff;
      incoming_in  = incoming_ff;
      removed_in   = removed_ff;
      freed_in     = freed_ff;
      rsp_valid_in = 1'b0;
      rsp_num_in   = rsp_num_ff;
      rsp_cyc_in   = rsp_cyc_ff;
      rsp_last_in  = rsp_last_ff;
      clear_all    = 1'b0;

      if (csr_we) begin
         vcount_in = csr_wdata;
      end

      unique case (state_ff)
         bmts_pkg::ST_IDLE: begin
            if (accept && req_start_sort) begin
               n_in        = eff_count;
               idx_in      = '0;
               emitted_in  = '0;
               incoming_in = '0;
               removed_in  = '0;
               state_in    = bmts_pkg::ST_SCAN;
            end
         end
         bmts_pkg::ST_SCAN: begin
            if (!removed_ff[idx_ff]) begin
               incoming_in = incoming_ff | rd_data;
            end
            if (idx_at_end) begin
               state_in = bmts_pkg::ST_CHECK;
            end else begin
               idx_in = idx_ff + bmts_pkg::IDX_W'(1);
            end
         end
         bmts_pkg::ST_CHECK: begin
            idx_in   = '0;
            freed_in = freed_now;
            if (freed_now == '0) begin
               // Nothing is free while vertices remain: report the cycle.
               rsp_valid_in = 1'b1;
               rsp_num_in   = '0;
               rsp_cyc_in   = 1'b1;
               rsp_last_in  = 1'b1;
               clear_all    = 1'b1;
               state_in     = bmts_pkg::ST_IDLE;
            end else begin
               state_in = bmts_pkg::ST_EMIT;
            end
         end
         bmts_pkg::ST_EMIT: begin
            if (freed_ff[idx_ff]) begin
               rsp_valid_in        = 1'b1;
               rsp_num_in          = {1'b0, idx_ff} + bmts_pkg::CNT_W'(1);
               rsp_cyc_in          = 1'b0;
               rsp_last_in         = (emitted_ff + bmts_pkg::CNT_W'(1) == n_ff);
               removed_in[idx_ff]  = 1'b1;
               emitted_in          = emitted_ff + bmts_pkg::CNT_W'(1);
            end
            if (freed_ff[idx_ff] && (emitted_ff + bmts_pkg::CNT_W'(1) == n_ff)) begin
               clear_all = 1'b1;
               state_in  = bmts_pkg::ST_IDLE;
            end else if (idx_at_end) begin
               idx_in      = '0;
               incoming_in = '0;
               state_in    = bmts_pkg::ST_SCAN;
            end else begin
               idx_in = idx_ff + bmts_pkg::IDX_W'(1);
            end
         end
         default: begin
            state_in = bmts_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bmts_pkg::ST_IDLE;
         vcount_ff    <= bmts_pkg::RESET_VERTEX_COUNT;
         rsp_valid_ff <= 1'b0;
         n_ff         <= '0;
         idx_ff       <= '0;
         emitted_ff   <= '0;
         removed_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         vcount_ff    <= vcount_in;
         rsp_valid_ff <= rsp_valid_in;
         n_ff         <= n_in;
         idx_ff       <= idx_in;
         emitted_ff   <= emitted_in;
         removed_ff   <= removed_in;
      end
   end

   always_ff @(posedge clock) begin
      incoming_ff <= incoming_in;
      freed_ff    <= freed_in;
      rsp_num_ff  <= rsp_num_in;
      rsp_cyc_ff  <= rsp_cyc_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_vertex_number = rsp_num_ff;
   assign rsp_cycle_found   = rsp_cyc_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

`default_nettype wire

@@ test/tb_bit_matrix_topological_sort.sv @@
`timescale 1ns / 100ps

module tb_bit_matrix_topological_sort;

   localparam int MAX_VERTICES  = bmts_pkg::DEFAULT_MAX_VERTICES;
   localparam int RANDOM_ROWS   = 190;
   localparam int SETTLE_CYCLES = 4;
   localparam int STALL_LIMIT   = 2000;

   typedef struct packed {
      logic [bmts_pkg::CNT_W-1:0] vertex_number;
      logic                       cycle_found;
      logic                       last;
   } sort_result_type;

   logic                           clock;
   logic                           reset          = 1'b1;
   logic                           start          = 1'b0;
   logic                           busy;
   logic [bmts_pkg::IDX_W-1:0]     req_row_index  = '0;
   logic [bmts_pkg::ROW_SLOTS-1:0] req_row_bits   = '0;
   logic                           req_start_sort = 1'b0;
   logic                           rsp_valid;
   logic [bmts_pkg::CNT_W-1:0]     rsp_vertex_number;
   logic                           rsp_cycle_found;
   logic                           rsp_last;
   logic                           csr_we         = 1'b0;
   logic [bmts_pkg::CNT_W-1:0]     csr_wdata      = '0;

   logic [bmts_pkg::ROW_SLOTS-1:0] graph_rows [bmts_pkg::ROW_SLOTS] = '{default: '0};
   logic [bmts_pkg::CNT_W-1:0]     model_vertex_count = bmts_pkg::RESET_VERTEX_COUNT;
   sort_result_type                expected_order [$];
   int                             mismatch_count = 0;
   int                             rows_sent = 0;
   int                             idle_cycles = 0;
   bit                             burst_mode = 1'b0;

   bit_matrix_topological_sort #(
      .MAX_VERTICES(MAX_VERTICES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_row_index(req_row_index),
      .req_row_bits(req_row_bits),
      .req_start_sort(req_start_sort),
      .rsp_valid(rsp_valid),
      .rsp_vertex_number(rsp_vertex_number),
      .rsp_cycle_found(rsp_cycle_found),
      .rsp_last(rsp_last),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int effective_vertices(logic [bmts_pkg::CNT_W-1:0] count);
      int n;
      n = count;
      if (n == 0) n = 1;
      if (n > MAX_VERTICES) n = MAX_VERTICES;
      if (n > bmts_pkg::ROW_SLOTS) n = bmts_pkg::ROW_SLOTS;
      return n;
   endfunction

   // Stores the row and, when sort_now is set, runs the layered sort to produce
   // the vertex order the block should emit.
   task automatic predict_sort_order(logic [bmts_pkg::IDX_W-1:0] idx,
                                     logic [bmts_pkg::ROW_SLOTS-1:0] bits,
                                     logic sort_now);
      logic [bmts_pkg::ROW_SLOTS-1:0] all_mask, gone, incoming, freed;
      int                             n, emitted;
      bit                             stuck;
      sort_result_type                item;
      graph_rows[idx] = bits;
      if (!sort_now) return;
      n = effective_vertices(model_vertex_count);
      all_mask = (n >= bmts_pkg::ROW_SLOTS) ? '1 : ((32'h1 << n) - 1);
      gone = '0;
      emitted = 0;
      stuck = 1'b0;
      while (emitted < n && !stuck) begin
         incoming = '0;
         for (int i = 0; i < n; i++)
            if (!gone[i]) incoming |= graph_rows[i];
         freed = ~incoming & ~gone & all_mask;
         if (freed == '0) begin
            item = '0;
            item.cycle_found = 1'b1;
            expected_order.push_back(item);
            stuck = 1'b1;
         end else begin
            for (int i = 0; i < n; i++) begin
               if (freed[i]) begin
                  item = '0;
                  item.vertex_number = bmts_pkg::CNT_W'(i + 1);
                  expected_order.push_back(item);
                  graph_rows[i] = '0;
                  gone[i] = 1'b1;
                  emitted++;
               end
            end
         end
      end
      item = expected_order.pop_back();
      item.last = 1'b1;
      expected_order.push_back(item);
      foreach (graph_rows[i]) graph_rows[i] = '0;
   endtask

   function automatic int pick_gap();
      int r;
      if (burst_mode) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [bmts_pkg::CNT_W-1:0] pick_vertex_count();
      int r;
      r = $urandom_range(99);
      if (r < 55) return bmts_pkg::CNT_W'($urandom_range(1, 8));
      if (r < 80) return bmts_pkg::CNT_W'($urandom_range(9, 31));
      if (r < 92) return bmts_pkg::CNT_W'(bmts_pkg::ROW_SLOTS);
      if (r < 96) return '0;
      return bmts_pkg::CNT_W'($urandom_range(33, 63));
   endfunction

   task automatic send_row(int idx, logic [bmts_pkg::ROW_SLOTS-1:0] bits, logic sort_now);
      int gap;
      req_row_index  <= bmts_pkg::IDX_W'(idx);
      req_row_bits   <= bits;
      req_start_sort <= sort_now;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
      predict_sort_order(bmts_pkg::IDX_W'(idx), bits, sort_now);
      rows_sent++;
      gap = pick_gap();
      // Start drops after a sort item so that the item is not taken again when busy falls.
      if (gap > 0 || sort_now) begin
         start <= 1'b0;
         repeat ((gap > 0) ? gap : 1) @(posedge clock);
      end
   endtask

   task automatic wait_until_idle();
      do @(posedge clock); while (expected_order.size() != 0 || busy);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_vertex_count(logic [bmts_pkg::CNT_W-1:0] value);
      wait_until_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      model_vertex_count = value;
      csr_we <= 1'b0;
   endtask

   // With no edges every vertex is free in the first round.
   task automatic test_empty_graph();
      send_row(0, '0, 1'b1);
   endtask

   task automatic test_full_row_self_loop();
      send_row(31, '1, 1'b1);
   endtask

   task automatic test_chain_loads();
      write_vertex_count(6'd4);
      send_row(0, 32'h0000_0002, 1'b0);
      send_row(1, 32'h0000_0004, 1'b0);
      send_row(2, 32'h0000_0008, 1'b0);
      send_row(3, 32'h0000_0000, 1'b1);
   endtask

   // Vertices 1 and 2 point at each other, so the sort stops after 0 and 3.
   task automatic test_partial_cycle();
      send_row(0, 32'h0000_0002, 1'b0);
      send_row(1, 32'h0000_0004, 1'b0);
      send_row(2, 32'h0000_0002, 1'b0);
      send_row(3, 32'hFFFF_FFF0, 1'b1);
   endtask

   task automatic test_count_limits();
      write_vertex_count(6'd1);
      send_row(5, '1, 1'b0);
      send_row(0, 32'hFFFF_FFFE, 1'b1);
      send_row(0, 32'h0000_0001, 1'b1);
      write_vertex_count(6'd0);
      send_row(0, '0, 1'b1);
      write_vertex_count(6'd63);
      send_row(31, 32'h0000_0001, 1'b1);
      write_vertex_count(6'd33);
      send_row(16, 32'h5555_AAAA, 1'b1);
      write_vertex_count(6'd32);
   endtask

   task automatic test_random_graphs();
      int                             perm [bmts_pkg::ROW_SLOTS];
      int                             rank [bmts_pkg::ROW_SLOTS];
      logic [bmts_pkg::ROW_SLOTS-1:0] rows [bmts_pkg::ROW_SLOTS];
      int                             first_row, n, density, tmp, j, u, v, k;
      first_row = rows_sent;
      while (rows_sent - first_row < RANDOM_ROWS) begin
         if ($urandom_range(99) < 40) write_vertex_count(pick_vertex_count());
         burst_mode = ($urandom_range(99) < 25);
         n = effective_vertices(model_vertex_count);
         if ($urandom_range(99) < 10) begin
            k = $urandom_range(1, 6);
            for (j = 0; j < k; j++)
               send_row($urandom_range(bmts_pkg::ROW_SLOTS - 1), $urandom,
                        (j == k - 1) || ($urandom_range(99) < 20));
         end else begin
            for (j = 0; j < bmts_pkg::ROW_SLOTS; j++) perm[j] = j;
            for (j = n - 1; j > 0; j--) begin
               u = $urandom_range(j);
               tmp = perm[j]; perm[j] = perm[u]; perm[u] = tmp;
            end
            for (j = 0; j < n; j++) rank[perm[j]] = j;
            density = $urandom_range(0, 60);
            // Edges here only go forward in a hidden order, so these edges alone form no cycle.
            for (u = 0; u < n; u++) begin
               rows[u] = '0;
               for (v = 0; v < n; v++)
                  if (rank[u] < rank[v] && $urandom_range(99) < density) rows[u][v] = 1'b1;
               if (n < bmts_pkg::ROW_SLOTS && $urandom_range(1))
                  rows[u] |= $urandom & ~((32'h1 << n) - 1);
            end
            if ($urandom_range(99) < 25) begin
               u = $urandom_range(n - 1);
               v = $urandom_range(n - 1);
               if (rank[u] < rank[v]) begin
                  tmp = u; u = v; v = tmp;
               end
               rows[u][v] = 1'b1;
            end
            if (n < bmts_pkg::ROW_SLOTS && $urandom_range(99) < 30)
               send_row($urandom_range(bmts_pkg::ROW_SLOTS - 1, n), $urandom, 1'b0);
            for (j = n - 1; j > 0; j--) begin
               u = $urandom_range(j);
               tmp = perm[j]; perm[j] = perm[u]; perm[u] = tmp;
            end
            for (j = 0; j < n; j++) begin
               u = perm[j];
               if (j == n - 1) send_row(u, rows[u], 1'b1);
               else if (rows[u] != '0 || $urandom_range(1)) send_row(u, rows[u], 1'b0);
            end
         end
      end
      burst_mode = 1'b0;
   endtask

   always @(posedge clock) begin
      sort_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_order.size() == 0) begin
            $display("%0t: unexpected result, expected none, got vertex %0d cycle %0b last %0b",
                     $time, rsp_vertex_number, rsp_cycle_found, rsp_last);
            mismatch_count++;
         end else begin
            want = expected_order.pop_front();
            if (rsp_vertex_number !== want.vertex_number) begin
               $display("%0t: vertex_number expected %0d, got %0d",
                        $time, want.vertex_number, rsp_vertex_number);
               mismatch_count++;
            end
            if (rsp_cycle_found !== want.cycle_found) begin
               $display("%0t: cycle_found expected %0b, got %0b",
                        $time, want.cycle_found, rsp_cycle_found);
               mismatch_count++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last expected %0b, got %0b", $time, want.last, rsp_last);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_empty_graph();
      test_full_row_self_loop();
      test_chain_loads();
      test_partial_cycle();
      test_count_limits();
      test_random_graphs();
      wait_until_idle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/bmts_pkg.sv
rtl/bmts_row_store.sv
rtl/bit_matrix_topological_sort.sv
test/tb_bit_matrix_topological_sort.sv
